>>> rtl/coesdo_pkg.sv
// shared types and constants for the coe sdo server responder
// no dependencies
package coesdo_pkg;

  localparam int unsigned BlobBytes    = 512;
  localparam int unsigned MailboxBytes = 128;

  localparam logic [3:0] MbxTypeCoe = 4'h3;
  localparam logic [3:0] CoeSdoReq  = 4'h2;

  localparam logic [7:0] CmdUpReq    = 8'h40;
  localparam logic [7:0] CmdCaUp     = 8'h50;
  localparam logic [7:0] CmdCaDn     = 8'h31;
  localparam logic [7:0] CmdSegMask  = 8'hEF;
  localparam logic [7:0] CmdSegReq   = 8'h60;
  localparam logic [7:0] CmdExpMask  = 8'hF3;
  localparam logic [7:0] CmdDnExp    = 8'h23;
  localparam logic [7:0] CmdDnNormal = 8'h21;

  localparam logic [7:0] RspAbort    = 8'h80;
  localparam logic [7:0] RspDnExp    = 8'h60;
  localparam logic [7:0] RspUpNormal = 8'h21;
  localparam logic [7:0] RspUpExp    = 8'h23;
  localparam logic [7:0] RspUpExp1   = 8'h2F;
  localparam logic [7:0] RspSegTog   = 8'h10;

  localparam logic [31:0] AbortAccess  = 32'h0601_0000;
  localparam logic [31:0] AbortNoObj   = 32'h0602_0000;
  localparam logic [31:0] AbortLength  = 32'h0607_0012;
  localparam logic [31:0] AbortCommand = 32'h0504_0001;

  localparam logic [15:0] ObjIdentity = 16'h1018;
  localparam logic [15:0] ObjGains    = 16'h8000;
  localparam logic [15:0] ObjBlob     = 16'h8001;

  localparam logic [7:0] ShortLen = 8'h0a;

  localparam logic [7:0] RegVendor   = 8'd0;
  localparam logic [7:0] RegProduct  = 8'd1;
  localparam logic [7:0] RegRevision = 8'd2;
  localparam logic [7:0] RegSerial   = 8'd3;

  typedef struct packed {
    logic [7:0]  len;
    logic [7:0]  cmd;
    logic [15:0] idx;
    logic [7:0]  sub;
    logic [31:0] val;
    logic        seg;
    logic [7:0]  base;
    logic [7:0]  cnt;
    logic [5:0]  words;
  } desc_t;

endpackage

>>> rtl/coesdo_front.sv
// front end: classifies requests, keeps gains and upload session state
// depends on coesdo_pkg
module coesdo_front #(
  parameter int unsigned BLOB_BYTES    = coesdo_pkg::BlobBytes,
  parameter int unsigned MAILBOX_BYTES = coesdo_pkg::MailboxBytes
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [3:0]         mailbox_type_i,
  input  logic [3:0]         coe_service_i,
  input  logic [7:0]         command_i,
  input  logic [15:0]        index_i,
  input  logic [7:0]         subindex_i,
  input  logic [31:0]        data_word_i,
  input  logic [31:0]        vendor_id_i,
  input  logic [31:0]        product_code_i,
  input  logic [31:0]        revision_number_i,
  input  logic [31:0]        serial_number_i,
  output logic               push_o,
  output coesdo_pkg::desc_t  desc_o
);

  localparam int unsigned FirstMax = MAILBOX_BYTES - 16;
  localparam int unsigned First    = (BLOB_BYTES < FirstMax) ? BLOB_BYTES : FirstMax;
  localparam int unsigned SegMax   = MAILBOX_BYTES - 9;
  localparam int unsigned MaxWords = MAILBOX_BYTES / 4;

  logic [31:0] gain_p_q, gain_p_d, gain_i_q, gain_i_d, gain_d_q, gain_d_d;
  logic        active_q, active_d;
  logic [15:0] obj_q, obj_d;
  logic [7:0]  sub_q, sub_d;
  logic [9:0]  total_q, total_d, done_q, done_d;
  logic        tog_q, tog_d;

  logic        small_hit, small_one;
  logic [31:0] small_val, dn_data;
  logic [9:0]  chunk_full, chunk;
  logic        fin, tog;
  logic [8:0]  nbytes;
  logic [6:0]  nwords;
  coesdo_pkg::desc_t d;

  always_comb begin
    small_hit = 1'b1;
    small_one = 1'b0;
    small_val = '0;
    if (index_i == coesdo_pkg::ObjIdentity) begin
      unique case (subindex_i)
        8'd0: begin small_val = 32'd4; small_one = 1'b1; end
        8'd1: small_val = vendor_id_i;
        8'd2: small_val = product_code_i;
        8'd3: small_val = revision_number_i;
        8'd4: small_val = serial_number_i;
        default: small_hit = 1'b0;
      endcase
    end else if (index_i == coesdo_pkg::ObjGains) begin
      unique case (subindex_i)
        8'd0: begin small_val = 32'd3; small_one = 1'b1; end
        8'd1: small_val = gain_p_q;
        8'd2: small_val = gain_i_q;
        8'd3: small_val = gain_d_q;
        default: small_hit = 1'b0;
      endcase
    end else begin
      small_hit = 1'b0;
    end
  end

  always_comb begin
    unique case (command_i[3:2])
      2'd0: dn_data = data_word_i;
      2'd1: dn_data = {8'h00, data_word_i[23:0]};
      2'd2: dn_data = {16'h0000, data_word_i[15:0]};
      default: dn_data = {24'h000000, data_word_i[7:0]};
    endcase
  end

  always_comb begin
    gain_p_d = gain_p_q;
    gain_i_d = gain_i_q;
    gain_d_d = gain_d_q;
    active_d = active_q;
    obj_d    = obj_q;
    sub_d    = sub_q;
    total_d  = total_q;
    done_d   = done_q;
    tog_d    = tog_q;
    d        = '0;
    d.len    = coesdo_pkg::ShortLen;
    tog      = command_i[4];
    chunk_full = total_q - done_q;
    fin      = chunk_full <= 10'(SegMax);
    chunk    = fin ? chunk_full : 10'(SegMax);
    push_o   = accept_i && mailbox_type_i == coesdo_pkg::MbxTypeCoe
               && coe_service_i == coesdo_pkg::CoeSdoReq;

    if (command_i == coesdo_pkg::CmdCaUp || command_i == coesdo_pkg::CmdCaDn) begin
      d.cmd = coesdo_pkg::RspAbort;
      d.val = coesdo_pkg::AbortAccess;
    end else if (command_i == coesdo_pkg::CmdUpReq) begin
      if (small_hit) begin
        d.cmd = small_one ? coesdo_pkg::RspUpExp1 : coesdo_pkg::RspUpExp;
        d.idx = index_i;
        d.sub = subindex_i;
        d.val = small_val;
      end else if (index_i == coesdo_pkg::ObjBlob && subindex_i == 8'd0) begin
        d.len = 8'(10 + First);
        d.cmd = coesdo_pkg::RspUpNormal;
        d.idx = index_i;
        d.sub = subindex_i;
        d.val = 32'(BLOB_BYTES);
        d.cnt = 8'(First);
        if (BLOB_BYTES > First) begin
          if (push_o) begin
            active_d = 1'b1;
            obj_d    = index_i;
            sub_d    = subindex_i;
            total_d  = 10'(BLOB_BYTES);
            done_d   = 10'(First);
            tog_d    = 1'b0;
          end
        end else if (push_o) begin
          active_d = 1'b0;
        end
      end else begin
        d.cmd = coesdo_pkg::RspAbort;
        d.val = coesdo_pkg::AbortNoObj;
      end
    end else if ((command_i & coesdo_pkg::CmdSegMask) == coesdo_pkg::CmdSegReq) begin
      if (!active_q || tog != tog_q) begin
        d.cmd = coesdo_pkg::RspAbort;
        d.val = coesdo_pkg::AbortCommand;
        if (push_o) active_d = 1'b0;
      end else if (obj_q != coesdo_pkg::ObjBlob || sub_q != 8'd0
                   || total_q != 10'(BLOB_BYTES) || done_q > total_q) begin
        d.cmd = coesdo_pkg::RspAbort;
        d.val = coesdo_pkg::AbortNoObj;
        if (push_o) active_d = 1'b0;
      end else begin
        if (fin && chunk < 10'd7) begin
          d.len = coesdo_pkg::ShortLen;
          d.cmd = 8'(8'd1 + ((8'd7 - chunk[7:0]) << 1));
        end else begin
          d.len = 8'(chunk + 10'd3);
          d.cmd = {7'd0, fin};
        end
        d.cmd  = d.cmd + (tog ? coesdo_pkg::RspSegTog : 8'h00);
        d.seg  = 1'b1;
        d.base = done_q[7:0];
        d.cnt  = chunk[7:0];
        if (push_o) begin
          done_d = done_q + chunk;
          if (fin) active_d = 1'b0;
          else tog_d = ~tog_q;
        end
      end
    end else if ((command_i & coesdo_pkg::CmdExpMask) == coesdo_pkg::CmdDnExp) begin
      if (index_i != coesdo_pkg::ObjGains || subindex_i < 8'd1 || subindex_i > 8'd3) begin
        d.cmd = coesdo_pkg::RspAbort;
        d.val = coesdo_pkg::AbortNoObj;
      end else begin
        d.cmd = coesdo_pkg::RspDnExp;
        d.idx = index_i;
        d.sub = subindex_i;
        if (push_o) begin
          if (subindex_i == 8'd1) gain_p_d = dn_data;
          else if (subindex_i == 8'd2) gain_i_d = dn_data;
          else gain_d_d = dn_data;
        end
      end
    end else if (command_i == coesdo_pkg::CmdDnNormal) begin
      d.cmd = coesdo_pkg::RspAbort;
      d.val = coesdo_pkg::AbortLength;
    end else begin
      d.cmd = coesdo_pkg::RspAbort;
      d.val = coesdo_pkg::AbortCommand;
    end

    nbytes  = 9'd6 + {1'b0, d.len};
    nwords  = 7'((nbytes + 9'd3) >> 2);
    d.words = (nwords > 7'(MaxWords)) ? 6'(MaxWords) : nwords[5:0];
    desc_o  = d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= '0;
      gain_i_q <= '0;
      gain_d_q <= '0;
      active_q <= 1'b0;
      obj_q    <= '0;
      sub_q    <= '0;
      total_q  <= '0;
      done_q   <= '0;
      tog_q    <= 1'b0;
    end else begin
      gain_p_q <= gain_p_d;
      gain_i_q <= gain_i_d;
      gain_d_q <= gain_d_d;
      active_q <= active_d;
      obj_q    <= obj_d;
      sub_q    <= sub_d;
      total_q  <= total_d;
      done_q   <= done_d;
      tog_q    <= tog_d;
    end
  end

endmodule

>>> rtl/coesdo_fifo.sv
// two-entry queue of response descriptors between front and back
// depends on coesdo_pkg
module coesdo_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  coesdo_pkg::desc_t desc_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              pop_i,
  output coesdo_pkg::desc_t desc_o
);

  coesdo_pkg::desc_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign desc_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= desc_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

>>> rtl/coesdo_back.sv
// back end: streams response frame words from a descriptor
// depends on coesdo_pkg
module coesdo_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  coesdo_pkg::desc_t desc_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [31:0]       frame_word_o,
  output logic [4:0]        word_index_o,
  output logic              last_o
);

  logic [4:0]  w_q, w_d;
  logic        valid_q;
  logic [31:0] word_q, word_d;
  logic [4:0]  idx_q;
  logic        last_q;
  logic        load, last_w;

  function automatic logic [7:0] byte_at(coesdo_pkg::desc_t d, logic [6:0] b);
    logic [8:0] nbytes;
    logic [7:0] start, off, v;
    nbytes = 9'd6 + {1'b0, d.len};
    start  = d.seg ? 8'd9 : 8'd16;
    off    = {1'b0, b} - start;
    v      = 8'h00;
    if ({1'b0, b} >= start && off < d.cnt) begin
      v = d.base + off;
    end else begin
      unique case (b)
        7'd0:  v = d.len;
        7'd5:  v = 8'h03;
        7'd7:  v = 8'h30;
        7'd8:  v = d.cmd;
        7'd9:  v = d.seg ? 8'h00 : d.idx[7:0];
        7'd10: v = d.seg ? 8'h00 : d.idx[15:8];
        7'd11: v = d.seg ? 8'h00 : d.sub;
        7'd12: v = d.seg ? 8'h00 : d.val[7:0];
        7'd13: v = d.seg ? 8'h00 : d.val[15:8];
        7'd14: v = d.seg ? 8'h00 : d.val[23:16];
        7'd15: v = d.seg ? 8'h00 : d.val[31:24];
        default: v = 8'h00;
      endcase
    end
    if ({2'b00, b} >= nbytes) v = 8'h00;
    return v;
  endfunction

  always_comb begin
    load   = valid_i && (!valid_q || !out_stall_i);
    last_w = ({1'b0, w_q} + 6'd1) == desc_i.words;
    pop_o  = load && last_w;
    w_d    = w_q;
    if (load) w_d = last_w ? 5'd0 : w_q + 5'd1;
    for (int j = 0; j < 4; j++) begin
      word_d[8*j +: 8] = byte_at(desc_i, {w_q, 2'(j)});
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_d;
      idx_q  <= w_q;
      last_q <= last_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q     <= 5'd0;
      valid_q <= 1'b0;
    end else begin
      w_q     <= w_d;
      valid_q <= load || (valid_q && out_stall_i);
    end
  end

  assign out_valid_o  = valid_q;
  assign frame_word_o = word_q;
  assign word_index_o = idx_q;
  assign last_o       = last_q;

endmodule

>>> rtl/coe_sdo_server_responder.sv
// top level of the coe sdo server responder: registers, front, queue, back
// depends on coesdo_pkg, coesdo_front, coesdo_fifo, coesdo_back
//
// channel  | handshake               | payload
// in       | in_valid_i / in_stall_o | mailbox_type, coe_service, command, index, ...
// out      | out_valid_o/out_stall_i | frame_word, word_index, last
// cfg      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// a request is taken while the queue is not full; its frame leaves at one word per cycle
// unless out_stall_i holds it, 4 to 32 words, so the output port sets the sustained rate
// a two-entry descriptor queue lets the next requests be taken during streaming
// asynchronous active-low reset clears gains, session and queue
// an output stall holds the word; a full queue stalls the input
module coe_sdo_server_responder #(
  parameter int unsigned BLOB_BYTES    = coesdo_pkg::BlobBytes,
  parameter int unsigned MAILBOX_BYTES = coesdo_pkg::MailboxBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  mailbox_type_i,
  input  logic [3:0]  coe_service_i,
  input  logic [7:0]  command_i,
  input  logic [15:0] index_i,
  input  logic [7:0]  subindex_i,
  input  logic [31:0] data_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] frame_word_o,
  output logic [4:0]  word_index_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] vendor_q, product_q, revision_q, serial_q;
  logic        full, push, fvalid, pop;
  coesdo_pkg::desc_t desc_in, desc_out;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vendor_q   <= '0;
      product_q  <= '0;
      revision_q <= '0;
      serial_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        coesdo_pkg::RegVendor:   vendor_q   <= cfg_data_i;
        coesdo_pkg::RegProduct:  product_q  <= cfg_data_i;
        coesdo_pkg::RegRevision: revision_q <= cfg_data_i;
        coesdo_pkg::RegSerial:   serial_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  coesdo_front #(
    .BLOB_BYTES   (BLOB_BYTES),
    .MAILBOX_BYTES(MAILBOX_BYTES)
  ) u_front (
    .clk_i,
    .rst_ni,
    .accept_i         (in_valid_i && !full),
    .mailbox_type_i,
    .coe_service_i,
    .command_i,
    .index_i,
    .subindex_i,
    .data_word_i,
    .vendor_id_i      (vendor_q),
    .product_code_i   (product_q),
    .revision_number_i(revision_q),
    .serial_number_i  (serial_q),
    .push_o           (push),
    .desc_o           (desc_in)
  );

  coesdo_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .desc_i (desc_in),
    .full_o (full),
    .valid_o(fvalid),
    .pop_i  (pop),
    .desc_o (desc_out)
  );

  coesdo_back u_back (
    .clk_i,
    .rst_ni,
    .valid_i     (fvalid),
    .desc_i      (desc_out),
    .pop_o       (pop),
    .out_valid_o,
    .out_stall_i,
    .frame_word_o,
    .word_index_o,
    .last_o
  );

endmodule

>>> rtl/coesdo_checker.sv
// port-level checks for the coe sdo server responder, bound to the top level
// depends on coe_sdo_server_responder
module coesdo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] frame_word_o,
  input logic [4:0]  word_index_o,
  input logic        last_o
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(frame_word_o)
    && $stable(word_index_o) && $stable(last_o))
    else $error("stalled output changed");

  // words of one frame leave back to back in order
  a_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o
    && word_index_o == $past(word_index_o) + 5'd1)
    else $error("frame word sequence broken");

  // fixed mailbox and coe header word
  a_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && word_index_o == 5'd1 |-> frame_word_o == 32'h3000_0300)
    else $error("bad header word");

  // first word carries only the length and never ends a frame
  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && word_index_o == 5'd0 |-> frame_word_o[31:16] == 16'h0000 && !last_o)
    else $error("bad first word");

endmodule

bind coe_sdo_server_responder coesdo_checker u_chk (
  .clk_i,
  .rst_ni,
  .out_valid_o,
  .out_stall_i,
  .frame_word_o,
  .word_index_o,
  .last_o
);

>>> bench/testbench.sv
// self-checking testbench for coe_sdo_server_responder: sdo requests in, frame words out
// depends on coesdo_pkg and the responder rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]  mtype;
    logic [3:0]  svc;
    logic [7:0]  cmd;
    logic [15:0] idx;
    logic [7:0]  sub;
    logic [31:0] data;
  } sdo_req_t;

  typedef struct packed {
    logic [31:0] word;
    logic [4:0]  pos;
    logic        last;
  } frame_word_t;

  localparam logic [3:0] Mt = coesdo_pkg::MbxTypeCoe;
  localparam logic [3:0] Sv = coesdo_pkg::CoeSdoReq;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o;
  logic [3:0] mailbox_type_i, coe_service_i;
  logic [7:0] command_i, subindex_i;
  logic [15:0] index_i;
  logic [31:0] data_word_i;
  logic out_valid_o, out_stall_i;
  logic [31:0] frame_word_o;
  logic [4:0] word_index_o;
  logic last_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [7:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  coe_sdo_server_responder uut (.*);

  // predictor state
  logic [31:0] id_regs [4];
  logic [31:0] gains [3];
  logic        sess_on;
  logic [15:0] sess_obj;
  logic [7:0]  sess_sub;
  logic [9:0]  sess_total, sess_done;
  logic        sess_tog;
  logic [7:0]  fbuf [128];

  frame_word_t frame_q[$];
  int errors = 0;
  bit stall_en = 1;

  localparam int unsigned FirstMax = coesdo_pkg::MailboxBytes - 16;
  localparam int unsigned SegMax   = coesdo_pkg::MailboxBytes - 9;

  function automatic void put16(int at, logic [15:0] v);
    fbuf[at] = v[7:0];
    fbuf[at+1] = v[15:8];
  endfunction

  function automatic void put32(int at, logic [31:0] v);
    put16(at, v[15:0]);
    put16(at+2, v[31:16]);
  endfunction

  function automatic void start_frame(int len, logic [7:0] cmd);
    foreach (fbuf[i]) fbuf[i] = 8'h00;
    put16(0, len[15:0]);
    fbuf[5] = 8'h03;
    put16(6, 16'h3000);
    fbuf[8] = cmd;
  endfunction

  function automatic void abort_frame(logic [31:0] code);
    start_frame(coesdo_pkg::ShortLen, coesdo_pkg::RspAbort);
    put32(12, code);
  endfunction

  function automatic void do_upload(logic [15:0] idx, logic [7:0] sub);
    logic [31:0] v;
    int len;
    bit hit;
    len = 4;
    hit = 1;
    if (idx == coesdo_pkg::ObjIdentity && sub == 0) begin
      v = 4; len = 1;
    end else if (idx == coesdo_pkg::ObjIdentity && sub >= 1 && sub <= 4) begin
      v = id_regs[sub-1];
    end else if (idx == coesdo_pkg::ObjGains && sub == 0) begin
      v = 3; len = 1;
    end else if (idx == coesdo_pkg::ObjGains && sub >= 1 && sub <= 3) begin
      v = gains[sub-1];
    end else begin
      hit = 0;
    end
    if (hit) begin
      start_frame(coesdo_pkg::ShortLen, coesdo_pkg::RspUpExp | 8'((4 - len) << 2));
      put16(9, idx);
      fbuf[11] = sub;
      put32(12, len == 1 ? (v & 32'hFF) : v);
    end else if (idx != coesdo_pkg::ObjBlob || sub != 0) begin
      abort_frame(coesdo_pkg::AbortNoObj);
    end else begin
      int first;
      first = coesdo_pkg::BlobBytes > FirstMax ? FirstMax : coesdo_pkg::BlobBytes;
      start_frame(coesdo_pkg::ShortLen + first, coesdo_pkg::RspUpNormal);
      put16(9, idx);
      fbuf[11] = sub;
      put32(12, coesdo_pkg::BlobBytes);
      for (int k = 0; k < first && 16 + k < 128; k++) fbuf[16+k] = 8'(k);
      if (coesdo_pkg::BlobBytes > first) begin
        sess_on = 1; sess_obj = idx; sess_sub = sub;
        sess_total = 10'(coesdo_pkg::BlobBytes); sess_done = 10'(first); sess_tog = 0;
      end else begin
        sess_on = 0;
      end
    end
  endfunction

  function automatic void do_segment(logic [7:0] cmd);
    logic tog;
    int chunk, flen;
    logic [7:0] c;
    bit fin;
    tog = cmd[4];
    fin = 1;
    if (!sess_on || tog != sess_tog) begin
      abort_frame(coesdo_pkg::AbortCommand);
      sess_on = 0;
    end else if (sess_obj != coesdo_pkg::ObjBlob || sess_sub != 0
                 || sess_total != 10'(coesdo_pkg::BlobBytes)
                 || sess_done > sess_total) begin
      abort_frame(coesdo_pkg::AbortNoObj);
      sess_on = 0;
    end else begin
      chunk = sess_total - sess_done;
      if (chunk > SegMax) begin
        chunk = SegMax; fin = 0;
      end
      if (fin && chunk < 7) begin
        flen = coesdo_pkg::ShortLen;
        c = 8'(1 + ((7 - chunk) << 1));
      end else begin
        flen = chunk + 3;
        c = fin ? 8'h01 : 8'h00;
      end
      start_frame(flen, c + (tog ? coesdo_pkg::RspSegTog : 8'h00));
      for (int k = 0; k < chunk && 9 + k < 128; k++) fbuf[9+k] = 8'(sess_done + k);
      sess_done = 10'(sess_done + chunk);
      if (fin) sess_on = 0;
      else sess_tog = ~sess_tog;
    end
  endfunction

  function automatic void do_download(logic [15:0] idx, logic [7:0] sub, logic [7:0] cmd,
                                      logic [31:0] data);
    int len;
    len = 4 - cmd[3:2];
    if (len < 4) data &= (32'h1 << (8 * len)) - 1;
    if (idx != coesdo_pkg::ObjGains || sub < 1 || sub > 3) begin
      abort_frame(coesdo_pkg::AbortNoObj);
    end else begin
      gains[sub-1] = data;
      start_frame(coesdo_pkg::ShortLen, coesdo_pkg::RspDnExp);
      put16(9, idx);
      fbuf[11] = sub;
    end
  endfunction

  // computes the response frame of one request and queues its words
  function automatic void predict_response(sdo_req_t r);
    int nbytes, nwords;
    frame_word_t f;
    if (r.mtype != coesdo_pkg::MbxTypeCoe || r.svc != coesdo_pkg::CoeSdoReq) return;
    if (r.cmd == coesdo_pkg::CmdCaUp || r.cmd == coesdo_pkg::CmdCaDn)
      abort_frame(coesdo_pkg::AbortAccess);
    else if (r.cmd == coesdo_pkg::CmdUpReq) do_upload(r.idx, r.sub);
    else if ((r.cmd & coesdo_pkg::CmdSegMask) == coesdo_pkg::CmdSegReq) do_segment(r.cmd);
    else if ((r.cmd & coesdo_pkg::CmdExpMask) == coesdo_pkg::CmdDnExp)
      do_download(r.idx, r.sub, r.cmd, r.data);
    else if (r.cmd == coesdo_pkg::CmdDnNormal) abort_frame(coesdo_pkg::AbortLength);
    else abort_frame(coesdo_pkg::AbortCommand);
    nbytes = 6 + {fbuf[1], fbuf[0]};
    nwords = (nbytes + 3) / 4;
    if (nwords > coesdo_pkg::MailboxBytes / 4) nwords = coesdo_pkg::MailboxBytes / 4;
    for (int w = 0; w < nwords; w++) begin
      f.word = {fbuf[4*w+3], fbuf[4*w+2], fbuf[4*w+1], fbuf[4*w]};
      if (4 * w + 4 > nbytes) f.word &= (32'h1 << (8 * (nbytes - 4 * w))) - 1;
      f.pos = 5'(w);
      f.last = (w + 1 == nwords);
      frame_q.push_back(f);
    end
  endfunction

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("testbench: done, errors");
    $finish;
  end

  // receiver stall pattern and checker
  initial begin
    out_stall_i = 0;
    forever begin
      @(posedge clk_i);
      out_stall_i <= stall_en && ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk_i) begin
    frame_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_q.size() == 0) begin
        $error("unexpected transfer: frame_word %h", frame_word_o);
        errors++;
      end else begin
        e = frame_q.pop_front();
        if (frame_word_o !== e.word) begin
          $error("frame_word expected %h actual %h", e.word, frame_word_o); errors++;
        end
        if (word_index_o !== e.pos) begin
          $error("word_index expected %0d actual %0d", e.pos, word_index_o); errors++;
        end
        if (last_o !== e.last) begin
          $error("last expected %0d actual %0d", e.last, last_o); errors++;
        end
      end
    end
  end

  task automatic send_req(sdo_req_t r);
    in_valid_i <= 1;
    mailbox_type_i <= r.mtype; coe_service_i <= r.svc; command_i <= r.cmd;
    index_i <= r.idx; subindex_i <= r.sub; data_word_i <= r.data;
    do @(posedge clk_i); while (in_stall_o);
    predict_response(r);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] ri, logic [31:0] v);
    cfg_valid_i <= 1; cfg_index_i <= ri; cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    id_regs[ri] = v;
  endtask

  task automatic write_ids(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
    write_reg(coesdo_pkg::RegVendor, a);
    write_reg(coesdo_pkg::RegProduct, b);
    write_reg(coesdo_pkg::RegRevision, c);
    write_reg(coesdo_pkg::RegSerial, d);
  endtask

  function automatic sdo_req_t mk(logic [7:0] cmd, logic [15:0] idx, logic [7:0] sub,
                                  logic [31:0] data);
    return '{Mt, Sv, cmd, idx, sub, data};
  endfunction

  function automatic sdo_req_t rand_req();
    sdo_req_t r;
    int k;
    logic [7:0] cmds [8];
    cmds = '{coesdo_pkg::CmdUpReq, coesdo_pkg::CmdSegReq,
             coesdo_pkg::CmdSegReq | coesdo_pkg::RspSegTog, coesdo_pkg::CmdDnExp,
             8'h27, 8'h2B, 8'h2F, coesdo_pkg::CmdUpReq};
    r = mk(cmds[$urandom_range(0, 7)], 16'h0, 8'($urandom_range(0, 5)), $urandom);
    k = $urandom_range(0, 9);
    case (k)
      0, 1, 2: r.idx = coesdo_pkg::ObjGains;
      3, 4:    r.idx = coesdo_pkg::ObjIdentity;
      5, 6:    r.idx = coesdo_pkg::ObjBlob;
      7:       r.idx = 16'($urandom);
      default: r.idx = coesdo_pkg::ObjGains;
    endcase
    if ($urandom_range(0, 9) == 0) r.cmd = 8'($urandom);
    if ($urandom_range(0, 14) == 0) r.sub = 8'($urandom);
    if ($urandom_range(0, 11) == 0) begin
      r.mtype = 4'($urandom);
      r.svc = 4'($urandom);
    end
    return r;
  endfunction

  typedef struct {
    sdo_req_t    req;
    bit          known;
    logic [31:0] word3;
  } dir_row_t;

  dir_row_t dir_tab [] = '{
    '{'{Mt, Sv, coesdo_pkg::CmdUpReq, coesdo_pkg::ObjIdentity, 8'd0, 32'h0}, 1, 32'h4},
    '{'{Mt, Sv, coesdo_pkg::CmdUpReq, coesdo_pkg::ObjIdentity, 8'd1, 32'h0}, 0, 32'h0},
    '{'{Mt, Sv, coesdo_pkg::CmdUpReq, coesdo_pkg::ObjIdentity, 8'd4, 32'h0}, 0, 32'h0},
    '{'{Mt, Sv, coesdo_pkg::CmdUpReq, coesdo_pkg::ObjGains, 8'd0, 32'h0}, 1, 32'h3},
    '{'{Mt, Sv, coesdo_pkg::CmdDnExp, coesdo_pkg::ObjGains, 8'd1, 32'hFFFF_FFFF},
      0, 32'h0},
    '{'{Mt, Sv, 8'h2F, coesdo_pkg::ObjGains, 8'd2, 32'hFFFF_FFFF}, 0, 32'h0},
    '{'{Mt, Sv, 8'h2B, coesdo_pkg::ObjGains, 8'd3, 32'hA5A5_5A5A}, 0, 32'h0},
    '{'{Mt, Sv, 8'h27, coesdo_pkg::ObjGains, 8'd3, 32'h1234_5678}, 0, 32'h0},
    '{'{Mt, Sv, coesdo_pkg::CmdUpReq, coesdo_pkg::ObjGains, 8'd3, 32'h0}, 0, 32'h0},
    '{'{Mt, Sv, coesdo_pkg::CmdCaUp, coesdo_pkg::ObjGains, 8'd1, 32'h0},
      1, coesdo_pkg::AbortAccess},
    '{'{Mt, Sv, coesdo_pkg::CmdCaDn, coesdo_pkg::ObjGains, 8'd1, 32'h0},
      1, coesdo_pkg::AbortAccess},
    '{'{Mt, Sv, coesdo_pkg::CmdDnNormal, coesdo_pkg::ObjGains, 8'd1, 32'h0},
      1, coesdo_pkg::AbortLength},
    '{'{Mt, Sv, 8'hFF, 16'hFFFF, 8'hFF, 32'h0}, 1, coesdo_pkg::AbortCommand},
    '{'{Mt, Sv, coesdo_pkg::CmdUpReq, 16'hFFFF, 8'hFF, 32'h0}, 1, coesdo_pkg::AbortNoObj},
    '{'{Mt, Sv, coesdo_pkg::CmdDnExp, coesdo_pkg::ObjIdentity, 8'd1, 32'h0},
      1, coesdo_pkg::AbortNoObj},
    '{'{Mt, Sv, coesdo_pkg::CmdSegReq, 16'h0, 8'd0, 32'h0}, 1, coesdo_pkg::AbortCommand},
    '{'{4'hF, 4'hF, coesdo_pkg::CmdUpReq, coesdo_pkg::ObjGains, 8'd1, 32'h0}, 0, 32'h0},
    '{'{4'h0, Sv, coesdo_pkg::CmdUpReq, coesdo_pkg::ObjGains, 8'd1, 32'h0}, 0, 32'h0},
    '{'{Mt, Sv, coesdo_pkg::CmdUpReq, coesdo_pkg::ObjBlob, 8'd0, 32'h0}, 0, 32'h0},
    '{'{Mt, Sv, coesdo_pkg::CmdUpReq, coesdo_pkg::ObjGains, 8'd1, 32'h0}, 0, 32'h0},
    '{'{Mt, Sv, coesdo_pkg::CmdSegReq, 16'h0, 8'd0, 32'h0}, 0, 32'h0},
    '{'{Mt, Sv, coesdo_pkg::CmdSegReq | coesdo_pkg::RspSegTog, 16'h0, 8'd0, 32'h0},
      0, 32'h0},
    '{'{Mt, Sv, coesdo_pkg::CmdSegReq, 16'h0, 8'd0, 32'h0}, 0, 32'h0},
    '{'{Mt, Sv, coesdo_pkg::CmdSegReq | coesdo_pkg::RspSegTog, 16'h0, 8'd0, 32'h0},
      0, 32'h0},
    '{'{Mt, Sv, coesdo_pkg::CmdSegReq | coesdo_pkg::RspSegTog, 16'h0, 8'd0, 32'h0},
      0, 32'h0}
  };

  initial begin
    int n, burst;
    bit paused;
    rst_ni = 0;
    in_valid_i = 0; mailbox_type_i = 0; coe_service_i = 0; command_i = 0;
    index_i = 0; subindex_i = 0; data_word_i = 0;
    cfg_valid_i = 0; cfg_index_i = 0; cfg_data_i = 0;
    foreach (id_regs[i]) id_regs[i] = 0;
    foreach (gains[i]) gains[i] = 0;
    sess_on = 0; sess_obj = 0; sess_sub = 0; sess_total = 0; sess_done = 0; sess_tog = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    repeat (2) @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_req(dir_tab[i].req);
      if (dir_tab[i].known) begin
        if (frame_q[$].word !== dir_tab[i].word3) begin
          $error("row %0d word3 expected %h predicted %h", i, dir_tab[i].word3,
                 frame_q[$].word);
          errors++;
        end
      end
      if (i == 3) begin
        drain();
        write_ids(32'hFFFF_FFFF, 32'h0, 32'h8000_0001, 32'h7FFF_FFFE);
      end
    end
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: write_ids(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        1: write_ids($urandom, $urandom, $urandom, $urandom);
        default: write_ids(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      endcase
      stall_en = (phase != 1);
      n = 0;
      paused = 0;
      while (n < 32) begin
        burst = $urandom_range(1, 8);
        if ($urandom_range(0, 2) == 0) begin
          // well-formed blob upload with its segment chain
          send_req(mk(coesdo_pkg::CmdUpReq, coesdo_pkg::ObjBlob, 8'd0, $urandom));
          for (int s = 0; s < 4; s++)
            send_req(mk(coesdo_pkg::CmdSegReq | (s[0] ? coesdo_pkg::RspSegTog : 8'h00),
                        16'($urandom), 8'($urandom), $urandom));
          n += 5;
        end else begin
          for (int b = 0; b < burst; b++) begin
            send_req(rand_req());
            n++;
          end
        end
        if ($urandom_range(0, 1) == 0) begin
          in_valid_i <= 0;
          repeat ($urandom_range(1, 40)) @(posedge clk_i);
        end
        if (n >= 16 && !paused) begin
          paused = 1;
          in_valid_i <= 0;
          while (frame_q.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    stall_en = 0;
    repeat (200) @(posedge clk_i);
    if (errors == 0 && frame_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/coesdo_pkg.sv
rtl/coesdo_front.sv
rtl/coesdo_fifo.sv
rtl/coesdo_back.sv
rtl/coe_sdo_server_responder.sv
rtl/coesdo_checker.sv
bench/testbench.sv
